// ===== rtl/bmva_pkg.sv =====
package bmva_pkg;

    localparam int MAX_BOXES_DEF  = 16;
    localparam int COUNT_BITS_DEF = 16;
    localparam int USED_W         = 5;
    localparam int CFG_IDX_W      = 2;

    localparam logic [1:0] MODE_LOAD_PREV = 2'd0;
    localparam logic [1:0] MODE_LOAD_CURR = 2'd1;
    localparam logic [1:0] MODE_MATCH     = 2'd2;
    localparam logic [1:0] MODE_FINISH    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_PREV_USED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CURR_USED = 2'd1;

    typedef struct packed {
        logic signed [12:0] left;
        logic signed [12:0] top;
        logic [11:0]        w;
        logic [11:0]        h;
    } t_box;

    typedef struct packed {
        logic load;
        logic vote;
        logic scan;
        logic shift;
        logic clear;
    } t_row_ctrl;

    function automatic logic box_holds(t_box b, logic [11:0] x, logic [11:0] y);
        logic signed [13:0] sx;
        logic signed [13:0] sy;
        logic signed [13:0] l;
        logic signed [13:0] t;
        logic signed [13:0] re;
        logic signed [13:0] be;
        sx = $signed({2'b00, x});
        sy = $signed({2'b00, y});
        l  = $signed({b.left[12], b.left});
        t  = $signed({b.top[12], b.top});
        re = l + $signed({2'b00, b.w});
        be = t + $signed({2'b00, b.h});
        return (l <= sx) && (sx < re) && (t <= sy) && (sy < be);
    endfunction

endpackage

// ===== rtl/bmva_col_cell.sv =====
module bmva_col_cell
    import bmva_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_load,
    input  t_box        i_box,
    input  logic [11:0] i_x,
    input  logic [11:0] i_y,
    output logic        o_hit
);

    t_box r_box;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_box <= i_box;
        end
    end

    assign o_hit = box_holds(r_box, i_x, i_y);

endmodule

// ===== rtl/bmva_row_cell.sv =====
module bmva_row_cell
    import bmva_pkg::*;
#(
    parameter int MAX_BOXES  = MAX_BOXES_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    localparam int IW = $clog2(MAX_BOXES)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_row_ctrl             i_ctrl,
    input  logic                  i_active,
    input  t_box                  i_box,
    input  logic [11:0]           i_x,
    input  logic [11:0]           i_y,
    input  logic [MAX_BOXES-1:0]  i_col_hit,
    input  logic [IW-1:0]         i_scan_col,
    input  logic [IW-1:0]         i_shift_id,
    input  logic [COUNT_BITS-1:0] i_shift_cnt,
    output logic [IW-1:0]         o_best_id,
    output logic [COUNT_BITS-1:0] o_best_cnt
);

    t_box                  r_box;
    logic [COUNT_BITS-1:0] r_cnt [MAX_BOXES];
    logic [IW-1:0]         r_id;
    logic [COUNT_BITS-1:0] r_best;
    logic                  row_hit;
    logic [COUNT_BITS-1:0] scan_val;

    assign row_hit  = i_active && box_holds(r_box, i_x, i_y);
    assign scan_val = r_cnt[i_scan_col];

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_box <= i_box;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clear) begin
            for (int c = 0; c < MAX_BOXES; c++) begin
                r_cnt[c] <= '0;
            end
            r_best <= '0;
            r_id   <= '0;
        end else begin
            if (i_ctrl.vote && row_hit) begin
                for (int c = 0; c < MAX_BOXES; c++) begin
                    if (i_col_hit[c] && (r_cnt[c] != '1)) begin
                        r_cnt[c] <= r_cnt[c] + 1'b1;
                    end
                end
            end
            if (i_ctrl.scan && (scan_val > r_best)) begin
                r_best <= scan_val;
                r_id   <= i_scan_col;
            end else if (i_ctrl.shift) begin
                r_best <= i_shift_cnt;
                r_id   <= i_shift_id;
            end
        end
    end

    assign o_best_id  = r_id;
    assign o_best_cnt = r_best;

endmodule

// ===== rtl/box_match_vote_argmax_core.sv =====
// Box association by keypoint voting.
// Input channel (i_valid / o_stall): one word per item, mode selects the
// action. Loads write a box table entry in the accepting cycle and the
// block takes the next word in the following cycle. A match steps through
// accept, the current-box hit compare in the column cells (S_HIT), then
// the vote in the row cells (S_VOTE). A finish runs the argmax scan over
// min(curr_used, 16) columns, one column per cycle in every row cell at
// once, emits min(prev_used, 16) result words, one per cycle while
// i_stall is low, shifted down the row chain, then clears the counters.
// Output channel (o_valid / i_stall): a word holds while i_stall is high;
// o_stall stays high until the finish run has completed.
// Configuration (i_cfg_valid / o_cfg_ready): ready is always high; write
// only while idle. Index 0 sets prev_used, index 1 sets curr_used.
// Reset clears all counters and sets both counts to 16. Box tables are
// undefined until loaded.
module box_match_vote_argmax_core
    import bmva_pkg::*;
#(
    parameter int MAX_BOXES  = MAX_BOXES_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [1:0]           i_mode,
    input  logic [3:0]           i_box_index,
    input  logic signed [12:0]   i_box_left,
    input  logic signed [12:0]   i_box_top,
    input  logic [11:0]          i_box_width,
    input  logic [11:0]          i_box_height,
    input  logic [11:0]          i_prev_x,
    input  logic [11:0]          i_prev_y,
    input  logic [11:0]          i_curr_x,
    input  logic [11:0]          i_curr_y,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [3:0]           o_prev_box,
    output logic [3:0]           o_best_curr_box,
    output logic [15:0]          o_vote_count,
    output logic                 o_last,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [USED_W-1:0]    i_cfg_data
);

    localparam int IW = $clog2(MAX_BOXES);
    localparam int CW = $clog2(MAX_BOXES + 1);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_HIT   = 6'b000010,
        S_VOTE  = 6'b000100,
        S_SCAN  = 6'b001000,
        S_EMIT  = 6'b010000,
        S_CLEAR = 6'b100000
    } t_state;

    t_state              r_state, n_state;
    logic [USED_W-1:0]   r_prev_used, r_curr_used;
    logic [11:0]         r_px, r_py, r_cx, r_cy;
    logic [MAX_BOXES-1:0] r_hit;
    logic [CW-1:0]       r_col, n_col;
    logic [CW-1:0]       r_k, n_k;
    logic [CW-1:0]       np, nc;
    logic [7:0]          np_w, nc_w;
    logic                accept, out_take;
    t_box                in_box;
    t_row_ctrl           ctrl;
    logic [MAX_BOXES-1:0] col_hit;
    logic [IW-1:0]       id_chain  [MAX_BOXES+1];
    logic [COUNT_BITS-1:0] cnt_chain [MAX_BOXES+1];

    assign accept   = i_valid && !o_stall;
    assign out_take = o_valid && !i_stall;
    assign o_stall  = (r_state != S_IDLE);
    assign o_valid  = (r_state == S_EMIT);
    assign o_cfg_ready = 1'b1;

    assign np_w = 8'(r_prev_used);
    assign nc_w = 8'(r_curr_used);
    assign np   = (np_w > 8'(MAX_BOXES)) ? CW'(MAX_BOXES) : CW'(np_w);
    assign nc   = (nc_w > 8'(MAX_BOXES)) ? CW'(MAX_BOXES) : CW'(nc_w);

    assign in_box = '{left: i_box_left, top: i_box_top, w: i_box_width, h: i_box_height};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_used <= USED_W'(16);
            r_curr_used <= USED_W'(16);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_PREV_USED: r_prev_used <= i_cfg_data;
                CFG_CURR_USED: r_curr_used <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        n_col   = r_col;
        n_k     = r_k;
        case (r_state)
            S_IDLE: begin
                n_col = '0;
                n_k   = '0;
                if (accept && (i_mode == MODE_MATCH)) begin
                    n_state = S_HIT;
                end else if (accept && (i_mode == MODE_FINISH)) begin
                    if (nc != '0) begin
                        n_state = S_SCAN;
                    end else if (np != '0) begin
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_CLEAR;
                    end
                end
            end
            S_HIT:  n_state = S_VOTE;
            S_VOTE: n_state = S_IDLE;
            S_SCAN: begin
                n_col = r_col + 1'b1;
                if (r_col == nc - 1'b1) begin
                    n_state = (np != '0) ? S_EMIT : S_CLEAR;
                end
            end
            S_EMIT: begin
                if (out_take) begin
                    n_k = r_k + 1'b1;
                    if (r_k == np - 1'b1) begin
                        n_state = S_CLEAR;
                    end
                end
            end
            S_CLEAR: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_col   <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_col   <= n_col;
            r_k     <= n_k;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && (i_mode == MODE_MATCH)) begin
            r_px <= i_prev_x;
            r_py <= i_prev_y;
            r_cx <= i_curr_x;
            r_cy <= i_curr_y;
        end
        if (r_state == S_HIT) begin
            for (int c = 0; c < MAX_BOXES; c++) begin
                r_hit[c] <= col_hit[c] && (CW'(c) < nc);
            end
        end
    end

    assign id_chain[MAX_BOXES]  = '0;
    assign cnt_chain[MAX_BOXES] = '0;

    for (genvar g = 0; g < MAX_BOXES; g++) begin : g_cells
        t_row_ctrl rc;
        always_comb begin
            rc       = '0;
            rc.load  = accept && (i_mode == MODE_LOAD_PREV)
                       && ({28'd0, i_box_index} == 32'(g));
            rc.vote  = (r_state == S_VOTE);
            rc.scan  = (r_state == S_SCAN);
            rc.shift = out_take;
            rc.clear = (r_state == S_CLEAR);
        end

        bmva_col_cell u_col (
            .i_clk  (i_clk),
            .i_load (accept && (i_mode == MODE_LOAD_CURR)
                     && ({28'd0, i_box_index} == 32'(g))),
            .i_box  (in_box),
            .i_x    (r_cx),
            .i_y    (r_cy),
            .o_hit  (col_hit[g])
        );

        bmva_row_cell #(
            .MAX_BOXES  (MAX_BOXES),
            .COUNT_BITS (COUNT_BITS)
        ) u_row (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (rc),
            .i_active    (CW'(g) < np),
            .i_box       (in_box),
            .i_x         (r_px),
            .i_y         (r_py),
            .i_col_hit   (r_hit),
            .i_scan_col  (r_col[IW-1:0]),
            .i_shift_id  (id_chain[g+1]),
            .i_shift_cnt (cnt_chain[g+1]),
            .o_best_id   (id_chain[g]),
            .o_best_cnt  (cnt_chain[g])
        );
    end

    assign o_prev_box      = 4'(r_k);
    assign o_best_curr_box = 4'(id_chain[0]);
    assign o_last          = (r_k == np - 1'b1);

    if (COUNT_BITS > 16) begin : g_sat
        assign o_vote_count = (cnt_chain[0] > COUNT_BITS'(16'hFFFF))
                              ? 16'hFFFF : cnt_chain[0][15:0];
    end else begin : g_ext
        assign o_vote_count = 16'(cnt_chain[0]);
    end

endmodule

// ===== rtl/bmva_checker.sv =====
module bmva_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [3:0] o_prev_box,
    input logic       o_last
);

    a_emit_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("result word shown while input open");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result word after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_prev_box) && $stable(o_last))
        else $error("stalled word changed");

    a_sequence: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_last |=> o_valid && (o_prev_box == $past(o_prev_box) + 4'd1))
        else $error("result words out of order");

endmodule

bind box_match_vote_argmax_core bmva_checker u_bmva_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_stall    (o_stall),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_prev_box (o_prev_box),
    .o_last     (o_last)
);

// ===== test/box_match_vote_argmax_core_tb.sv =====
module box_match_vote_argmax_core_tb;
    import bmva_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NBOX       = 16;
    localparam int CYCLE_CAP  = 600000;
    localparam int SETTLE     = 40;

    typedef struct {
        logic [1:0]         mode;
        logic [3:0]         idx;
        logic signed [12:0] left;
        logic signed [12:0] top;
        logic [11:0]        w;
        logic [11:0]        h;
        logic [11:0]        px;
        logic [11:0]        py;
        logic [11:0]        cx;
        logic [11:0]        cy;
    } t_word;

    typedef struct {
        logic [3:0]  prev_box;
        logic [3:0]  best;
        logic [15:0] count;
        logic        last;
    } t_assoc;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic [1:0] i_mode = '0;
    logic [3:0] i_box_index = '0;
    logic signed [12:0] i_box_left = '0;
    logic signed [12:0] i_box_top = '0;
    logic [11:0] i_box_width = '0;
    logic [11:0] i_box_height = '0;
    logic [11:0] i_prev_x = '0;
    logic [11:0] i_prev_y = '0;
    logic [11:0] i_curr_x = '0;
    logic [11:0] i_curr_y = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic [3:0] o_prev_box;
    logic [3:0] o_best_curr_box;
    logic [15:0] o_vote_count;
    logic o_last;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [USED_W-1:0] i_cfg_data = '0;

    box_match_vote_argmax_core i_dut (.*);

    always #4 i_clk = ~i_clk;

    t_word  word_q[$];
    t_assoc assoc_q[$];
    int     errors = 0;
    int     cycles = 0;
    bit     word_busy = 0;
    bit     calm = 0;
    int     send_gap = 0;
    int     recv_gap = 0;

    // shadow state
    int          pl[NBOX], pt[NBOX], pw[NBOX], ph[NBOX];
    int          cl[NBOX], ct[NBOX], cw[NBOX], ch[NBOX];
    int unsigned votes[NBOX][NBOX];
    int          prev_used = 16;
    int          curr_used = 16;

    function automatic bit holds(int l, int t, int w, int h, int x, int y);
        return l <= x && x < l + w && t <= y && y < t + h;
    endfunction

    function automatic int gap_len();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 19);
        if (r < 11) return 0;
        if (r < 18) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic predict_word(t_word wd);
        int np, nc, best, best_id;
        bit hit[NBOX];
        np = prev_used > NBOX ? NBOX : prev_used;
        nc = curr_used > NBOX ? NBOX : curr_used;
        case (wd.mode)
            MODE_LOAD_PREV: begin
                pl[wd.idx] = wd.left; pt[wd.idx] = wd.top;
                pw[wd.idx] = wd.w;    ph[wd.idx] = wd.h;
            end
            MODE_LOAD_CURR: begin
                cl[wd.idx] = wd.left; ct[wd.idx] = wd.top;
                cw[wd.idx] = wd.w;    ch[wd.idx] = wd.h;
            end
            MODE_MATCH: begin
                for (int c = 0; c < nc; c++)
                    hit[c] = holds(cl[c], ct[c], cw[c], ch[c], wd.cx, wd.cy);
                for (int r = 0; r < np; r++)
                    if (holds(pl[r], pt[r], pw[r], ph[r], wd.px, wd.py))
                        for (int c = 0; c < nc; c++)
                            if (hit[c] && votes[r][c] < 65535) votes[r][c]++;
            end
            default: begin
                for (int r = 0; r < np; r++) begin
                    best = 0;
                    best_id = 0;
                    for (int c = 0; c < nc; c++)
                        if (votes[r][c] > best) begin
                            best = votes[r][c];
                            best_id = c;
                        end
                    assoc_q.insert(assoc_q.size(),
                        '{r[3:0], best_id[3:0], best[15:0], r == np - 1});
                end
                for (int r = 0; r < NBOX; r++)
                    for (int c = 0; c < NBOX; c++) votes[r][c] = 0;
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                predict_word('{i_mode, i_box_index, i_box_left, i_box_top, i_box_width,
                    i_box_height, i_prev_x, i_prev_y, i_curr_x, i_curr_y});
                word_busy = 0;
            end
            if (!i_valid || !o_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (word_q.size() > 0) begin
                    t_word wd;
                    wd = word_q.pop_front();
                    word_busy = 1;
                    i_mode <= wd.mode;
                    i_box_index <= wd.idx;
                    i_box_left <= wd.left;
                    i_box_top <= wd.top;
                    i_box_width <= wd.w;
                    i_box_height <= wd.h;
                    i_prev_x <= wd.px;
                    i_prev_y <= wd.py;
                    i_curr_x <= wd.cx;
                    i_curr_y <= wd.cy;
                    i_valid <= 1'b1;
                    send_gap = gap_len();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (assoc_q.size() == 0) begin
                    $display("%0t: unexpected word prev_box=%0d", $time, o_prev_box);
                    errors++;
                end else begin
                    t_assoc e;
                    e = assoc_q.pop_front();
                    if (o_prev_box !== e.prev_box) begin
                        $display("%0t: prev_box exp %0d got %0d", $time, e.prev_box, o_prev_box);
                        errors++;
                    end
                    if (o_best_curr_box !== e.best) begin
                        $display("%0t: best_curr_box exp %0d got %0d", $time, e.best,
                            o_best_curr_box);
                        errors++;
                    end
                    if (o_vote_count !== e.count) begin
                        $display("%0t: vote_count exp %0d got %0d", $time, e.count,
                            o_vote_count);
                        errors++;
                    end
                    if (o_last !== e.last) begin
                        $display("%0t: last exp %0d got %0d", $time, e.last, o_last);
                        errors++;
                    end
                end
            end
            if (recv_gap > 0) begin
                recv_gap--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
                recv_gap = gap_len();
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("box_match_vote_argmax_core_tb: done, errors");
            $finish;
        end
    end

    task automatic wait_idle();
        while (word_q.size() > 0 || word_busy || assoc_q.size() > 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [USED_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_PREV_USED) prev_used = int'(val);
        else curr_used = int'(val);
    endtask

    function automatic t_word blank(logic [1:0] mode);
        t_word wd;
        wd.mode = mode;
        wd.idx = 4'($urandom); wd.left = 13'($urandom); wd.top = 13'($urandom);
        wd.w = 12'($urandom); wd.h = 12'($urandom);
        wd.px = 12'($urandom); wd.py = 12'($urandom);
        wd.cx = 12'($urandom); wd.cy = 12'($urandom);
        return wd;
    endfunction

    function automatic t_word load_word(logic [1:0] mode, int idx, bit noisy);
        t_word wd;
        wd = blank(mode);
        wd.idx = 4'(idx);
        if (!noisy) begin
            wd.left = 13'($urandom_range(0, 300));
            wd.top = 13'($urandom_range(0, 300));
            wd.w = 12'($urandom_range(1, 200));
            wd.h = 12'($urandom_range(1, 200));
        end
        return wd;
    endfunction

    function automatic int inside_pt(int l, int w);
        int v;
        v = (w > 0) ? l + int'($urandom_range(0, w - 1)) : l;
        return v < 0 ? 0 : (v > 4095 ? 4095 : v);
    endfunction

    task automatic queue_match(bit noisy);
        t_word wd;
        int r, c;
        wd = blank(MODE_MATCH);
        if (!noisy) begin
            r = $urandom_range(0, NBOX - 1);
            c = $urandom_range(0, NBOX - 1);
            wd.px = 12'(inside_pt(pl[r], pw[r]));
            wd.py = 12'(inside_pt(pt[r], ph[r]));
            wd.cx = 12'(inside_pt(cl[c], cw[c]));
            wd.cy = 12'(inside_pt(ct[c], ch[c]));
        end
        word_q.insert(word_q.size(), wd);
    endtask

    int sent;
    t_word wd;

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < NBOX; i++) begin
            wd = load_word(MODE_LOAD_PREV, i, 0);
            predict_shadow: begin
                pl[i] = wd.left; pt[i] = wd.top; pw[i] = wd.w; ph[i] = wd.h;
            end
            word_q.insert(word_q.size(), wd);
            wd = load_word(MODE_LOAD_CURR, i, 0);
            cl[i] = wd.left; ct[i] = wd.top; cw[i] = wd.w; ch[i] = wd.h;
            word_q.insert(word_q.size(), wd);
        end
        wait_idle();

        // directed: extremes, edges, empty finish
        word_q.insert(word_q.size(), blank(MODE_FINISH));
        word_q.insert(word_q.size(), '{MODE_LOAD_PREV, 4'd15, -13'sd4096, 13'sd4095,
            12'd4095, 12'd0, 0, 0, 0, 0});
        word_q.insert(word_q.size(), '{MODE_LOAD_CURR, 4'd15, -13'sd4096, -13'sd4096,
            12'd4095, 12'd4095, 0, 0, 0, 0});
        word_q.insert(word_q.size(), '{MODE_LOAD_PREV, 4'd0, 13'sd0, 13'sd0,
            12'd4095, 12'd4095, 0, 0, 0, 0});
        word_q.insert(word_q.size(), '{MODE_LOAD_CURR, 4'd0, 13'sd4095, 13'sd4095,
            12'd4095, 12'd4095, 0, 0, 0, 0});
        word_q.insert(word_q.size(), '{MODE_LOAD_PREV, 4'd1, 13'sd10, 13'sd10,
            12'd5, 12'd5, 0, 0, 0, 0});
        word_q.insert(word_q.size(), '{MODE_LOAD_CURR, 4'd1, 13'sd10, 13'sd10,
            12'd5, 12'd5, 0, 0, 0, 0});
        word_q.insert(word_q.size(), '{MODE_MATCH, 0, 0, 0, 0, 0,
            12'd0, 12'd0, 12'd4095, 12'd4095});
        word_q.insert(word_q.size(), '{MODE_MATCH, 0, 0, 0, 0, 0,
            12'd4095, 12'd4095, 12'd0, 12'd0});
        word_q.insert(word_q.size(), '{MODE_MATCH, 0, 0, 0, 0, 0,
            12'd10, 12'd10, 12'd10, 12'd10});
        word_q.insert(word_q.size(), '{MODE_MATCH, 0, 0, 0, 0, 0,
            12'd14, 12'd14, 12'd14, 12'd14});
        word_q.insert(word_q.size(), '{MODE_MATCH, 0, 0, 0, 0, 0,
            12'd15, 12'd15, 12'd15, 12'd15});
        word_q.insert(word_q.size(), '{MODE_MATCH, 0, 0, 0, 0, 0,
            12'd9, 12'd10, 12'd10, 12'd9});
        word_q.insert(word_q.size(), '{MODE_MATCH, 0, 0, 0, 0, 0,
            12'd4095, 12'd4095, 12'd4095, 12'd4095});
        word_q.insert(word_q.size(), blank(MODE_FINISH));
        wait_idle();

        sent = 47;
        for (int ph_n = 0; sent < 222; ph_n++) begin
            calm = (ph_n % 4 == 3);
            case (ph_n % 6)
                0: begin write_reg(CFG_PREV_USED, 5'd0); write_reg(CFG_CURR_USED, 5'd16); end
                1: begin write_reg(CFG_PREV_USED, 5'd16); write_reg(CFG_CURR_USED, 5'd0); end
                2: begin write_reg(CFG_PREV_USED, 5'd31); write_reg(CFG_CURR_USED, 5'd1); end
                3: begin write_reg(CFG_PREV_USED, 5'd1); write_reg(CFG_CURR_USED, 5'd31); end
                4: begin
                    write_reg(CFG_PREV_USED, 5'($urandom_range(17, 30)));
                    write_reg(CFG_CURR_USED, 5'($urandom_range(17, 30)));
                end
                default: begin
                    write_reg(CFG_PREV_USED, 5'($urandom_range(1, 16)));
                    write_reg(CFG_CURR_USED, 5'($urandom_range(1, 16)));
                end
            endcase
            for (int k = $urandom_range(0, 3); k > 0; k--) begin
                wd = load_word(2'($urandom_range(0, 1)), $urandom_range(0, NBOX - 1),
                    $urandom_range(0, 3) == 0);
                word_q.insert(word_q.size(), wd);
                if (wd.mode == MODE_LOAD_PREV) begin
                    pl[wd.idx] = wd.left; pt[wd.idx] = wd.top;
                    pw[wd.idx] = wd.w;    ph[wd.idx] = wd.h;
                end else begin
                    cl[wd.idx] = wd.left; ct[wd.idx] = wd.top;
                    cw[wd.idx] = wd.w;    ch[wd.idx] = wd.h;
                end
                sent++;
            end
            for (int k = $urandom_range(3, 25); k > 0; k--) begin
                queue_match($urandom_range(0, 4) == 0);
                sent++;
            end
            word_q.insert(word_q.size(), blank(MODE_FINISH));
            sent++;
            wait_idle();
        end

        wait_idle();
        if (errors == 0 && assoc_q.size() == 0)
            $display("box_match_vote_argmax_core_tb: done, clean");
        else
            $display("box_match_vote_argmax_core_tb: done, errors");
        $finish;
    end

endmodule

// ===== box_match_vote_argmax_core.f =====
rtl/bmva_pkg.sv
rtl/bmva_col_cell.sv
rtl/bmva_row_cell.sv
rtl/box_match_vote_argmax_core.sv
rtl/bmva_checker.sv
test/box_match_vote_argmax_core_tb.sv
